FILE: rtl/srrw_pkg.sv
// Package for the selective-repeat reorder window: field widths, result kinds,
// status codes and parameter defaults.
// Depends on nothing; used by the top level and the bench.
`default_nettype none

package srrw_pkg;

    localparam int WINDOW_SLOTS_DEF = 32;
    localparam int MAX_PAYLOAD_DEF  = 512;

    localparam int SEQ_W    = 8;
    localparam int LEN_W    = 10;
    localparam int HANDLE_W = 16;
    localparam int TS_W     = 32;
    localparam int KIND_W   = 2;
    localparam int WIN_W    = 5;
    localparam int STAT_W   = 3;

    // Offsets at or above this value (modulo the sequence space) are late.
    localparam int LATE_OFFSET = 128;

    localparam int MAX_WINDOW_SLOTS = 128;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_STORED    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DELIVERED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_LATE      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BEYOND    = 3'd4;
    localparam logic [STAT_W-1:0] STAT_EOF       = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/srrw_ring_add.sv
// Ring index adder for the reorder window: adds two slot indexes modulo the
// number of slots. Shared by slot lookup, run scan and head advance.
// Depends on nothing but its parameter.
`default_nettype none

module srrw_ring_add #(
    parameter int WINDOW_SLOTS = 32
) (
    input  wire logic [$clog2(WINDOW_SLOTS)-1:0] i_a,
    input  wire logic [$clog2(WINDOW_SLOTS)-1:0] i_b,
    output logic      [$clog2(WINDOW_SLOTS)-1:0] o_sum
);

    localparam int PTR_W = $clog2(WINDOW_SLOTS);

    logic [PTR_W:0] w_sum;

    // Both operands are below the slot count, so one subtract wraps the sum.
    assign w_sum = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum = (w_sum >= (PTR_W+1)'(WINDOW_SLOTS))
                 ? PTR_W'(w_sum - (PTR_W+1)'(WINDOW_SLOTS))
                 : w_sum[PTR_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/selective_repeat_reorder_window_top.sv
// Selective-repeat reorder window, top level. Uses srrw_pkg and srrw_ring_add.
// Holds the slot ring, the sequencer and the output register.
//
// One packet is handled at a time and the input is not ready until its last
// result has been taken. A packet that releases a run of slots first scans the
// run one slot per cycle, then each release needs a read of the single slot
// memory port, a register load and the output transfer. One ring index adder
// serves slot lookup, the scan and the head advance. Slot valid bits are
// flip-flops cleared by reset, so no clearing pass is needed.
`default_nettype none

module selective_repeat_reorder_window_top #(
    parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF,
    parameter int MAX_PAYLOAD  = srrw_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // seq_num[7:0], payload_length[17:8], payload_handle[33:18], timestamp[65:34]
    input  wire logic [srrw_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // out_handle[15:0], out_length[25:16], ack_seq[33:26], ack_window[38:34],
    // ack_timestamp[70:39], status[73:71], end_of_file[74]
    output logic [srrw_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    // result_kind[1:0]
    output logic [srrw_pkg::KIND_W-1:0]             o_m_tuser,
    output logic                                    o_m_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready
);

    localparam int PTR_W  = $clog2(WINDOW_SLOTS);
    localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
    localparam int SEQ_W  = srrw_pkg::SEQ_W;
    localparam int LEN_W  = srrw_pkg::LEN_W;
    localparam int HND_W  = srrw_pkg::HANDLE_W;
    localparam int TS_W   = srrw_pkg::TS_W;
    localparam int WIN_W  = srrw_pkg::WIN_W;
    localparam int STAT_W = srrw_pkg::STAT_W;
    localparam int KIND_W = srrw_pkg::KIND_W;
    localparam int PAD_W  = srrw_pkg::OUT_TDATA_W
                          - (HND_W + LEN_W + SEQ_W + WIN_W + TS_W + STAT_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_SCAN,
        S_READ,
        S_EMIT,
        S_ACK,
        S_OUT
    } t_state;

    t_state r_state;
    t_state r_ret;

    logic [SEQ_W-1:0]  r_seq;
    logic [LEN_W-1:0]  r_len;
    logic [HND_W-1:0]  r_handle;
    logic [TS_W-1:0]   r_ts;

    logic [PTR_W-1:0]  r_head;
    logic [SEQ_W-1:0]  r_expected;
    logic [CNT_W-1:0]  r_free;
    logic [WINDOW_SLOTS-1:0] r_full;
    logic [WINDOW_SLOTS-1:0] r_zlen;

    logic [PTR_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_eof;
    logic [STAT_W-1:0] r_status;

    logic [HND_W-1:0]  mem_handle [WINDOW_SLOTS];
    logic [LEN_W-1:0]  mem_length [WINDOW_SLOTS];
    logic [HND_W-1:0]  r_rd_handle;
    logic [LEN_W-1:0]  r_rd_length;

    logic              r_o_valid;
    logic [KIND_W-1:0] r_o_kind;
    logic [HND_W-1:0]  r_o_handle;
    logic [LEN_W-1:0]  r_o_length;
    logic [SEQ_W-1:0]  r_o_aseq;
    logic [WIN_W-1:0]  r_o_win;
    logic [TS_W-1:0]   r_o_ts;
    logic [STAT_W-1:0] r_o_status;
    logic              r_o_eof;
    logic              r_o_last;

    logic [SEQ_W-1:0]  w_d;
    logic              w_late;
    logic              w_reject;
    logic [PTR_W-1:0]  w_add_a;
    logic [PTR_W-1:0]  w_add_b;
    logic [PTR_W-1:0]  w_sum;
    logic              w_store;
    logic [WIN_W-1:0]  w_window;

    assign w_d      = r_seq - r_expected;
    assign w_late   = (32'(w_d) >= 32'(srrw_pkg::LATE_OFFSET));
    assign w_reject = (32'(r_len) > 32'(MAX_PAYLOAD))
                   || (!w_late && (32'(w_d) >= 32'(WINDOW_SLOTS)));
    assign w_store  = (r_state == S_CLASS) && !w_reject && !w_late && !r_full[w_sum];
    assign w_window = (r_free == '0) ? '0 : WIN_W'(r_free - CNT_W'(1));

    // Operand selection for the shared ring adder.
    always_comb begin
        case (r_state)
            S_CLASS: begin
                w_add_a = r_head;
                w_add_b = w_d[PTR_W-1:0];
            end
            S_SCAN: begin
                w_add_a = r_ptr;
                w_add_b = PTR_W'(1);
            end
            default: begin
                w_add_a = r_head;
                w_add_b = PTR_W'(1);
            end
        endcase
    end

    srrw_ring_add #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) u_ring_add (
        .i_a  (w_add_a),
        .i_b  (w_add_b),
        .o_sum(w_sum)
    );

    // Slot payload memory: one write in the store cycle, one registered read
    // at the window head.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem_handle[w_sum] <= r_handle;
            mem_length[w_sum] <= r_len;
            r_zlen[w_sum]     <= (r_len == '0);
        end
        r_rd_handle <= mem_handle[r_head];
        r_rd_length <= mem_length[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_head     <= '0;
            r_expected <= '0;
            r_free     <= CNT_W'(WINDOW_SLOTS - 1);
            r_full     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_seq    <= i_s_tdata[SEQ_W-1:0];
                        r_len    <= i_s_tdata[SEQ_W +: LEN_W];
                        r_handle <= i_s_tdata[SEQ_W+LEN_W +: HND_W];
                        r_ts     <= i_s_tdata[SEQ_W+LEN_W+HND_W +: TS_W];
                        r_state  <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    if (w_reject) begin
                        r_o_valid  <= 1'b1;
                        r_o_kind   <= srrw_pkg::KIND_REJECT;
                        r_o_handle <= '0;
                        r_o_length <= '0;
                        r_o_aseq   <= '0;
                        r_o_win    <= '0;
                        r_o_ts     <= '0;
                        r_o_status <= srrw_pkg::STAT_BEYOND;
                        r_o_eof    <= 1'b0;
                        r_o_last   <= 1'b1;
                        r_ret      <= S_IDLE;
                        r_state    <= S_OUT;
                    end else if (w_late) begin
                        r_eof    <= 1'b0;
                        r_status <= srrw_pkg::STAT_LATE;
                        r_state  <= S_ACK;
                    end else if (r_full[w_sum]) begin
                        r_eof    <= 1'b0;
                        r_status <= srrw_pkg::STAT_DUPLICATE;
                        r_state  <= S_ACK;
                    end else begin
                        r_full[w_sum] <= 1'b1;
                        r_free        <= r_free - CNT_W'(1);
                        r_eof         <= 1'b0;
                        if ((w_sum == r_head) || r_full[r_head]) begin
                            r_ptr   <= r_head;
                            r_cnt   <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_status <= srrw_pkg::STAT_STORED;
                            r_state  <= S_ACK;
                        end
                    end
                end
                S_SCAN: begin
                    // Measure the run of full slots from the head and note
                    // whether any of them is an end-of-file packet.
                    if ((r_cnt < CNT_W'(WINDOW_SLOTS)) && r_full[r_ptr]) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_eof <= r_eof | r_zlen[r_ptr];
                        r_ptr <= w_sum;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_o_valid  <= 1'b1;
                    r_o_kind   <= srrw_pkg::KIND_DELIVER;
                    r_o_handle <= r_rd_handle;
                    r_o_length <= r_rd_length;
                    r_o_aseq   <= '0;
                    r_o_win    <= '0;
                    r_o_ts     <= '0;
                    r_o_status <= (r_rd_length == '0) ? srrw_pkg::STAT_EOF
                                                      : srrw_pkg::STAT_DELIVERED;
                    r_o_eof    <= r_eof;
                    r_o_last   <= 1'b0;
                    r_full[r_head] <= 1'b0;
                    r_head     <= w_sum;
                    r_expected <= r_expected + SEQ_W'(1);
                    r_free     <= r_free + CNT_W'(1);
                    r_cnt      <= r_cnt - CNT_W'(1);
                    r_status   <= r_eof ? srrw_pkg::STAT_EOF : srrw_pkg::STAT_DELIVERED;
                    r_ret      <= (r_cnt == CNT_W'(1)) ? S_ACK : S_READ;
                    r_state    <= S_OUT;
                end
                S_ACK: begin
                    r_o_valid  <= 1'b1;
                    r_o_kind   <= srrw_pkg::KIND_ACK;
                    r_o_handle <= '0;
                    r_o_length <= '0;
                    r_o_aseq   <= r_expected;
                    r_o_win    <= w_window;
                    r_o_ts     <= r_ts;
                    r_o_status <= r_status;
                    r_o_eof    <= r_eof;
                    r_o_last   <= 1'b1;
                    r_ret      <= S_IDLE;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_o_valid <= 1'b0;
                        r_state   <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_o_eof, r_o_status, r_o_ts, r_o_win,
                         r_o_aseq, r_o_length, r_o_handle};

endmodule

`default_nettype wire

FILE: bench/selective_repeat_reorder_window_top_tb.sv
// Self-checking bench for the selective-repeat reorder window top level.
// Needs srrw_pkg and the RTL only; packets are predicted in-bench when transferred
// and every result transfer is checked against the oldest pending prediction.
`timescale 1ns / 100ps

module selective_repeat_reorder_window_top_tb;

    localparam int NSLOTS       = srrw_pkg::WINDOW_SLOTS_DEF;
    localparam int MAX_LEN      = srrw_pkg::MAX_PAYLOAD_DEF;
    localparam int SEQ_W        = srrw_pkg::SEQ_W;
    localparam int LEN_W        = srrw_pkg::LEN_W;
    localparam int HANDLE_W     = srrw_pkg::HANDLE_W;
    localparam int TS_W         = srrw_pkg::TS_W;
    localparam int KIND_W       = srrw_pkg::KIND_W;
    localparam int WIN_W        = srrw_pkg::WIN_W;
    localparam int STAT_W       = srrw_pkg::STAT_W;
    localparam int IN_TDATA_W   = srrw_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W  = srrw_pkg::OUT_TDATA_W;
    localparam int LATE_OFFSET  = srrw_pkg::LATE_OFFSET;
    localparam int TOTAL_ITEMS  = 230;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    // Field order matches the input tdata layout, seq_num in the lowest bits.
    typedef struct packed {
        logic [TS_W-1:0]     ts;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic [SEQ_W-1:0]    seq;
    } t_packet;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic [SEQ_W-1:0]    aseq;
        logic [WIN_W-1:0]    awin;
        logic [TS_W-1:0]     ts;
        logic [STAT_W-1:0]   status;
        logic                eof;
        logic                last;
    } t_window_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    selective_repeat_reorder_window_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_packet        packets_to_send[$];
    t_window_result due_results[$];

    // Shadow copy of the reorder window.
    bit                  win_full[NSLOTS];
    logic [HANDLE_W-1:0] win_handle[NSLOTS];
    logic [LEN_W-1:0]    win_len[NSLOTS];
    int                  win_head = 0;
    logic [SEQ_W-1:0]    next_seq = '0;
    int                  free_cnt = NSLOTS - 1;

    int  n_queued = 0;
    int  in_count = 0;
    int  err_cnt = 0;
    int  idle_cycles = 0;
    bit  in_fire = 1'b0;

    int  burst_left = 0;
    int  gap_left = 0;
    int  rdy_mode = 0;
    int  mode_left = 0;
    int  phase = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    // Sorts one packet against the window and queues the results it must produce.
    task automatic window_accept(input t_packet p);
        logic [SEQ_W-1:0]  off;
        logic [STAT_W-1:0] st;
        logic              eof;
        int                pos;
        int                span;
        t_window_result    r;
        off = p.seq - next_seq;
        eof = 1'b0;
        if (p.len > MAX_LEN || (off >= NSLOTS && off < LATE_OFFSET)) begin
            r = '0;
            r.kind = srrw_pkg::KIND_REJECT;
            r.status = srrw_pkg::STAT_BEYOND;
            r.last = 1'b1;
            due_results.push_back(r);
            return;
        end
        if (off >= LATE_OFFSET) begin
            st = srrw_pkg::STAT_LATE;
        end else begin
            pos = (win_head + off) % NSLOTS;
            if (win_full[pos]) begin
                st = srrw_pkg::STAT_DUPLICATE;
            end else begin
                win_full[pos] = 1'b1;
                win_handle[pos] = p.handle;
                win_len[pos] = p.len;
                free_cnt--;
                if (!win_full[win_head]) begin
                    st = srrw_pkg::STAT_STORED;
                end else begin
                    span = 0;
                    while (span < NSLOTS && win_full[(win_head + span) % NSLOTS])
                        span++;
                    for (int i = 0; i < span; i++)
                        if (win_len[(win_head + i) % NSLOTS] == 0)
                            eof = 1'b1;
                    for (int i = 0; i < span; i++) begin
                        pos = (win_head + i) % NSLOTS;
                        r = '0;
                        r.kind = srrw_pkg::KIND_DELIVER;
                        r.handle = win_handle[pos];
                        r.len = win_len[pos];
                        r.status = (win_len[pos] == 0) ? srrw_pkg::STAT_EOF
                                                       : srrw_pkg::STAT_DELIVERED;
                        r.eof = eof;
                        due_results.push_back(r);
                        win_full[pos] = 1'b0;
                    end
                    free_cnt += span;
                    win_head = (win_head + span) % NSLOTS;
                    next_seq = SEQ_W'(next_seq + span);
                    st = eof ? srrw_pkg::STAT_EOF : srrw_pkg::STAT_DELIVERED;
                end
            end
        end
        r = '0;
        r.kind = srrw_pkg::KIND_ACK;
        r.aseq = next_seq;
        r.awin = (free_cnt == 0) ? '0 : WIN_W'(free_cnt - 1);
        r.ts = p.ts;
        r.status = st;
        r.eof = eof;
        r.last = 1'b1;
        due_results.push_back(r);
    endtask

    function automatic string result_str(input t_window_result r);
        return $sformatf({"kind=%0d hdl=%h len=%0d aseq=%0d win=%0d ts=%h",
                          " st=%0d eof=%b last=%b"},
                         r.kind, r.handle, r.len, r.aseq, r.awin, r.ts, r.status, r.eof,
                         r.last);
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        if ($urandom_range(0, 15) == 0)
            return '0;
        return LEN_W'($urandom_range(1, MAX_LEN));
    endfunction

    task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                               input logic [31:0] handle,
                               input logic [TS_W-1:0] ts);
        t_packet p;
        p.seq = seq;
        p.len = len;
        p.handle = HANDLE_W'(handle);
        p.ts = ts;
        packets_to_send.push_back(p);
        n_queued++;
    endtask

    // Waits until every queued packet has been transferred, and optionally until
    // every predicted result has come out as well.
    task automatic wait_for(input bit results_too);
        while (packets_to_send.size() != 0 || (results_too && due_results.size() != 0))
            @(posedge i_clk);
    endtask

    // Checks result transfers, predicts accepted packets and runs the watchdog.
    always @(posedge i_clk) begin : monitor
        t_window_result got;
        t_window_result want;
        string          bad;
        in_fire = i_rst_n && s_tvalid && s_tready;
        if (in_fire) begin
            window_accept(packets_to_send.pop_front());
            in_count++;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.handle = m_tdata[15:0];
            got.len = m_tdata[25:16];
            got.aseq = m_tdata[33:26];
            got.awin = m_tdata[38:34];
            got.ts = m_tdata[70:39];
            got.status = m_tdata[73:71];
            got.eof = m_tdata[74];
            got.last = m_tlast;
            if (due_results.size() == 0) begin
                if (err_cnt < 10)
                    $display("%0t: result with nothing expected: %s", $realtime,
                             result_str(got));
                err_cnt++;
            end else begin
                want = due_results.pop_front();
                bad = "";
                if (got.kind !== want.kind) bad = {bad, " kind"};
                if (got.handle !== want.handle) bad = {bad, " handle"};
                if (got.len !== want.len) bad = {bad, " length"};
                if (got.aseq !== want.aseq) bad = {bad, " ack_seq"};
                if (got.awin !== want.awin) bad = {bad, " ack_window"};
                if (got.ts !== want.ts) bad = {bad, " timestamp"};
                if (got.status !== want.status) bad = {bad, " status"};
                if (got.eof !== want.eof) bad = {bad, " eof"};
                if (got.last !== want.last) bad = {bad, " last"};
                if (bad != "") begin
                    if (err_cnt < 10) begin
                        $display("%0t: mismatch in%s", $realtime, bad);
                        $display("  expected %s", result_str(want));
                        $display("  actual   %s", result_str(got));
                    end
                    err_cnt++;
                end
            end
        end
        if (in_fire || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("selective_repeat_reorder_window_top_tb NOT OK");
            $finish;
        end
    end

    // Packet sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin : sender
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (packets_to_send.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= IN_TDATA_W'(packets_to_send[0]);
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Result consumer with its own stall modes and one long hold-off mid-run.
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && in_count >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                rdy_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rdy_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    2: m_tready <= (phase % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int               order[NSLOTS];
        int               cnt;
        int               sel;
        int               j;
        int               tmp;
        int               chunk_no;
        logic [SEQ_W-1:0] base;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from an empty window expecting sequence 0.
        send_packet(8'd1, 10'd512, 32'h0000_FFFF, 32'hFFFF_FFFF);  // stored ahead of the head
        send_packet(8'd1, 10'd7, $urandom, $urandom);         // duplicate
        send_packet(8'd31, 10'd0, 32'h0000_0000, 32'h0000_0000);   // end of file, far edge
        send_packet(8'd32, 10'd3, $urandom, $urandom);        // just beyond the window
        send_packet(8'd127, 10'd3, $urandom, $urandom);       // last offset beyond
        send_packet(8'd128, 10'd3, $urandom, $urandom);       // first late offset
        send_packet(8'd255, 10'd3, $urandom, $urandom);       // most recent late
        send_packet(8'd2, 10'd513, $urandom, $urandom);       // oversized payload
        send_packet(8'd0, 10'd1023, $urandom, $urandom);      // oversized, all length bits
        send_packet(8'd0, 10'd5, 32'h0000_0000, 32'h0000_0000);    // head fills, releases two
        send_packet(8'd3, 10'd9, $urandom, $urandom);
        send_packet(8'd2, 10'd1, $urandom, $urandom);
        send_packet(8'd4, 10'd0, $urandom, $urandom);         // end of file released at once
        send_packet(8'd0, 10'd8, $urandom, $urandom);         // late after the head moved
        send_packet(8'd36, 10'd11, $urandom, $urandom);       // last slot of the window

        chunk_no = 0;
        while (n_queued < TOTAL_ITEMS) begin
            wait_for(1'b0);
            if (chunk_no == 8)
                wait_for(1'b1);
            chunk_no++;
            base = next_seq;
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
                // Well-formed run of consecutive sequence numbers in random order.
                cnt = ($urandom_range(0, 5) == 0) ? NSLOTS : $urandom_range(1, 8);
                for (int i = 0; i < cnt; i++)
                    order[i] = i;
                for (int i = cnt - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                // A full window is sent with the head packet last, so it fills every slot.
                if (cnt == NSLOTS) begin
                    for (int i = 0; i < cnt; i++)
                        if (order[i] == 0) begin
                            order[i] = order[cnt - 1];
                            order[cnt - 1] = 0;
                        end
                end
                for (int i = 0; i < cnt; i++) begin
                    send_packet(SEQ_W'(base + order[i]), pick_len(), $urandom, $urandom);
                    if ($urandom_range(0, 7) == 0)
                        send_packet(SEQ_W'(base + order[i]), pick_len(), $urandom, $urandom);
                end
            end else if (sel <= 7) begin
                cnt = $urandom_range(1, 6);
                for (int i = 0; i < cnt; i++)
                    send_packet(SEQ_W'($urandom), ($urandom_range(0, 3) == 0) ?
                                LEN_W'($urandom_range(0, 1023)) : pick_len(),
                                $urandom, $urandom);
            end else if (sel == 8) begin
                cnt = $urandom_range(1, 4);
                for (int i = 0; i < cnt; i++)
                    if ($urandom_range(0, 1) == 0)
                        send_packet(SEQ_W'(base - $urandom_range(1, 128)), pick_len(),
                                    $urandom, $urandom);
                    else
                        send_packet(SEQ_W'(base + $urandom_range(NSLOTS, 127)), pick_len(),
                                    $urandom, $urandom);
            end else begin
                // Broken sequence: packets ahead of the head leave holes behind.
                cnt = $urandom_range(1, 6);
                for (int i = 0; i < cnt; i++)
                    send_packet(SEQ_W'(base + $urandom_range(1, NSLOTS - 1)), pick_len(),
                                $urandom, $urandom);
            end
        end

        wait_for(1'b1);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && due_results.size() == 0)
            $display("selective_repeat_reorder_window_top_tb OK");
        else
            $display("selective_repeat_reorder_window_top_tb NOT OK");
        $finish;
    end

endmodule
